[hdl/fat12_pkg.sv]
// Shared constants and codes for the FAT12 allocation table engine.
// No dependencies; compile first.
package fat12_pkg;

  localparam int TABLE_ENTRIES = 4096;
  localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
  localparam int DATA_W        = 12;
  localparam int CMD_W         = 2;

  localparam logic [DATA_W-1:0] MEDIA_MARK  = 12'hFF0;
  localparam logic [DATA_W-1:0] CHAIN_END   = 12'hFFF;
  localparam logic [DATA_W-1:0] COUNT_RESET = 12'd2847;

  localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIND  = 2'd2;

endpackage

[hdl/fat12_req_if.sv]
// Request channel: command, cluster number and entry value.
// Depends on fat12_pkg.
interface fat12_req_if;
  logic                          valid;
  logic                          ready;
  logic [fat12_pkg::CMD_W-1:0]   cmd;
  logic [fat12_pkg::DATA_W-1:0]  cluster;
  logic [fat12_pkg::DATA_W-1:0]  entry_value;

  modport source (output valid, cmd, cluster, entry_value, input ready);
  modport sink   (input valid, cmd, cluster, entry_value, output ready);
endinterface

[hdl/fat12_res_if.sv]
// Result channel: entry data or found cluster, found flag, range error.
// Depends on fat12_pkg.
interface fat12_res_if;
  logic                          valid;
  logic                          ready;
  logic [fat12_pkg::DATA_W-1:0]  read_data;
  logic                          found;
  logic                          range_error;

  modport source (output valid, read_data, found, range_error, input ready);
  modport sink   (input valid, read_data, found, range_error, output ready);
endinterface

[hdl/fat12_alloc_table_engine.sv]
// FAT12 allocation table engine: one table memory swept by a small sequencer.
// Depends on fat12_pkg, fat12_req_if and fat12_res_if.
//
// After reset the engine runs a clearing pass over all TABLE_ENTRIES (4096)
// entries that writes the media marker to entry 0, the end-of-chain marker to
// entry 1 and zero elsewhere; no request is taken until it ends. One request at
// a time is served through the single table read port: a read goes through a
// registered memory read, and a free-cluster search examines entries from 2 up
// to min(cluster_count+1, TABLE_ENTRIES-1), one per cycle; a search with an
// empty range (cluster_count 0) examines none. A finished result sits in an
// output register, so the next request is taken while it waits; while that
// register is still full, the engine holds the result in S_PUT.
module fat12_alloc_table_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [fat12_pkg::DATA_W-1:0]  cfg_wr_data,
  fat12_req_if.sink                     req,
  fat12_res_if.source                   res
);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_RDWAIT = 5'b00100,
    S_SCAN   = 5'b01000,
    S_PUT    = 5'b10000
  } state_t;

  localparam int AW = fat12_pkg::ADDR_W;
  localparam int DW = fat12_pkg::DATA_W;

  state_t          state;
  logic [DW-1:0]   cluster_count;

  logic [DW-1:0]   mem [fat12_pkg::TABLE_ENTRIES];
  logic [DW-1:0]   mem_q;
  logic [AW-1:0]   rd_addr;
  logic            mem_we;
  logic [AW-1:0]   wr_addr;
  logic [DW-1:0]   wr_data;

  logic [AW-1:0]   clr_addr;
  logic [AW-1:0]   scan_addr;
  logic [AW-1:0]   scan_last;
  logic            scan_more;
  logic [AW-1:0]   chk_addr;
  logic            chk_valid;

  logic [DW-1:0]   res_data;
  logic            res_found;
  logic            res_err;

  logic            req_fire;
  logic            in_range;
  logic [DW:0]     last_full;
  logic [DW:0]     last_clip;
  logic            out_free;

  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign in_range  = ({1'b0, req.cluster} < (DW+1)'(fat12_pkg::TABLE_ENTRIES));
  assign out_free  = !res.valid || res.ready;

  // last cluster searched: count+1, clipped to the last table entry
  assign last_full = {1'b0, cluster_count} + (DW+1)'(1);
  assign last_clip = (last_full > (DW+1)'(fat12_pkg::TABLE_ENTRIES - 1))
                     ? (DW+1)'(fat12_pkg::TABLE_ENTRIES - 1) : last_full;

  assign rd_addr = (state == S_SCAN) ? scan_addr : req.cluster[AW-1:0];

  always_comb begin
    mem_we  = 1'b0;
    wr_addr = req.cluster[AW-1:0];
    wr_data = req.entry_value;
    if (state == S_CLEAR) begin
      mem_we  = 1'b1;
      wr_addr = clr_addr;
      if (clr_addr == AW'(0)) begin
        wr_data = fat12_pkg::MEDIA_MARK;
      end else if (clr_addr == AW'(1)) begin
        wr_data = fat12_pkg::CHAIN_END;
      end else begin
        wr_data = '0;
      end
    end else if (req_fire && req.cmd == fat12_pkg::CMD_WRITE && in_range) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_count <= fat12_pkg::COUNT_RESET;
    end else if (cfg_wr_en) begin
      cluster_count <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      res.valid <= 1'b0;
      scan_more <= 1'b0;
      chk_valid <= 1'b0;
    end else begin
      if (state == S_PUT && out_free) begin
        res.valid <= 1'b1;
      end else if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(fat12_pkg::TABLE_ENTRIES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_fire) begin
            res_data  <= '0;
            res_found <= 1'b0;
            res_err   <= 1'b0;
            unique case (req.cmd)
              fat12_pkg::CMD_READ: begin
                if (in_range) begin
                  state <= S_RDWAIT;
                end else begin
                  res_err <= 1'b1;
                  state   <= S_PUT;
                end
              end
              fat12_pkg::CMD_WRITE: begin
                res_err <= !in_range;
                state   <= S_PUT;
              end
              fat12_pkg::CMD_FIND: begin
                scan_last <= last_clip[AW-1:0];
                scan_addr <= AW'(2);
                scan_more <= 1'b1;
                chk_valid <= 1'b0;
                if (last_clip < (DW+1)'(2)) begin
                  state <= S_PUT;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: begin
                state <= S_PUT;
              end
            endcase
          end
        end
        S_RDWAIT: begin
          res_data <= mem_q;
          state    <= S_PUT;
        end
        S_SCAN: begin
          // mem_q holds the entry at chk_addr; a read of scan_addr is in flight
          if (chk_valid && mem_q == '0) begin
            res_data  <= DW'(chk_addr);
            res_found <= 1'b1;
            state     <= S_PUT;
          end else if (chk_valid && chk_addr == scan_last) begin
            state <= S_PUT;
          end else if (scan_more) begin
            chk_addr  <= scan_addr;
            chk_valid <= 1'b1;
            scan_addr <= scan_addr + AW'(1);
            scan_more <= (scan_addr != scan_last);
          end else begin
            chk_valid <= 1'b0;
            state     <= S_PUT;
          end
        end
        S_PUT: begin
          // hold the result until the output register is free
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_PUT && out_free) begin
      res.read_data   <= res_data;
      res.found       <= res_found;
      res.range_error <= res_err;
    end
  end

endmodule
